// ===== rtl/smpq_pkg.sv =====
// sorted minimum priority queue: shared types, constants and command/status structs
// no dependencies; used by every module of the block except smpq_ram
`default_nettype none

package smpq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] removed_value;
		logic [COUNT_W-1:0]       count;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic step;
		logic wr_shift;
		logic wr_val_up;
		logic wr_val_at;
		logic fin_ins;
		logic fin_pop;
		logic fin_empty;
		logic fin_full;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic act_q;
		logic empty;
		logic full;
		logic less;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/smpq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module smpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/smpq_ctrl.sv =====
// sorted minimum priority queue: sequencing state machine
// depends on smpq_pkg (cmd_t, sts_t)
`default_nettype none

module smpq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire smpq_pkg::sts_t sts,
	output smpq_pkg::cmd_t     cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_READ   = 6'b000010,
		S_CMP    = 6'b000100,
		S_PLACE  = 6'b001000,
		S_POP    = 6'b010000,
		S_APPEND = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (sts.act == smpq_pkg::ACT_REMOVE) begin
						if (sts.empty) begin
							cmd.fin_empty = 1'b1;
						end else begin
							state_d = S_READ;
						end
					end else begin
						if (sts.full) begin
							cmd.fin_full = 1'b1;
						end else if (sts.empty) begin
							state_d = S_APPEND;
						end else begin
							state_d = S_READ;
						end
					end
				end
			end
			S_READ: begin
				state_d = (sts.act_q == smpq_pkg::ACT_REMOVE) ? S_POP : S_CMP;
			end
			S_CMP: begin
				if (sts.less) begin
					cmd.wr_val_up = 1'b1;
					cmd.fin_ins   = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.wr_shift = 1'b1;
					if (sts.last) begin
						state_d = S_PLACE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_READ;
					end
				end
			end
			S_PLACE: begin
				cmd.wr_val_at = 1'b1;
				cmd.fin_ins   = 1'b1;
				state_d       = S_IDLE;
			end
			S_POP: begin
				cmd.fin_pop = 1'b1;
				state_d     = S_IDLE;
			end
			S_APPEND: begin
				cmd.wr_val_up = 1'b1;
				cmd.fin_ins   = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/smpq_dp.sv =====
// sorted minimum priority queue: circular store, pointers, compare and result register
// depends on smpq_pkg and smpq_ram
`default_nettype none

module smpq_dp #(
	parameter int CAPACITY = smpq_pkg::CAPACITY
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire smpq_pkg::in_word_t  item,
	input  wire smpq_pkg::cmd_t      cmd,
	output smpq_pkg::sts_t           sts,
	output logic                     done,
	output smpq_pkg::out_word_t      result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = smpq_pkg::DATA_W;
	localparam int OW = smpq_pkg::COUNT_W;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] rem_q;
	logic          act_q;
	logic signed [DW-1:0] val_q;
	logic          done_q;
	smpq_pkg::out_word_t res_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic [DW-1:0] rdata;
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
		return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
	endfunction

	function automatic logic [OW-1:0] cnt_out(input logic [CW-1:0] c);
		logic [CW+OW-1:0] e;
		e = {{OW{1'b0}}, c};
		return e[OW-1:0];
	endfunction

	smpq_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_comb begin
		tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (tail_sum >= (CW+1)'(CAPACITY)) begin
			tail_sum = tail_sum - (CW+1)'(CAPACITY);
		end
		tail = tail_sum[AW-1:0];
	end

	always_comb begin
		we    = cmd.wr_shift | cmd.wr_val_up | cmd.wr_val_at;
		waddr = cmd.wr_val_at ? idx_q : wrap_inc(idx_q);
		wdata = cmd.wr_shift ? rdata : val_q;
	end

	assign sts.act   = item.action;
	assign sts.act_q = act_q;
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(CAPACITY));
	assign sts.less  = ($signed(rdata) < val_q);
	assign sts.last  = (rem_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin_ins | cmd.fin_pop | cmd.fin_empty | cmd.fin_full;
			if (cmd.fin_ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.fin_pop) begin
				count_q <= count_q - CW'(1);
				head_q  <= wrap_inc(head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= item.action;
			val_q <= item.value;
			rem_q <= count_q;
			idx_q <= (item.action == smpq_pkg::ACT_REMOVE) ? head_q : wrap_dec(tail);
		end else if (cmd.step) begin
			rem_q <= rem_q - CW'(1);
			idx_q <= wrap_dec(idx_q);
		end
		if (cmd.fin_ins) begin
			res_q.status        <= smpq_pkg::ST_INSERTED;
			res_q.removed_value <= '0;
			res_q.count         <= cnt_out(count_q + CW'(1));
		end else if (cmd.fin_pop) begin
			res_q.status        <= smpq_pkg::ST_REMOVED;
			res_q.removed_value <= rdata;
			res_q.count         <= cnt_out(count_q - CW'(1));
		end else if (cmd.fin_empty) begin
			res_q.status        <= smpq_pkg::ST_EMPTY;
			res_q.removed_value <= '0;
			res_q.count         <= cnt_out(count_q);
		end else if (cmd.fin_full) begin
			res_q.status        <= smpq_pkg::ST_FULL;
			res_q.removed_value <= '0;
			res_q.count         <= cnt_out(count_q);
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_min_priority_queue_core.sv =====
// sorted minimum priority queue, top level: controller plus datapath around a circular ram
// steps: refusals answer from idle; remove reads then pops the head; an insert into empty appends;
// other inserts repeat ram read then compare and write until a smaller value ends the search
// one word at a time; busy, unless refused, holds until the result strobe, which lasts one cycle
// reset: async active-low clears count, head, done and the state machine; ram contents not cleared
// the receiver cannot stall: done marks each result for exactly one cycle
`default_nettype none

module sorted_min_priority_queue_core #(
	parameter int CAPACITY = smpq_pkg::CAPACITY
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire smpq_pkg::in_word_t  item,
	output logic                     done,
	output smpq_pkg::out_word_t      result
);

	smpq_pkg::cmd_t cmd;
	smpq_pkg::sts_t sts;

	smpq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	smpq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.sts   (sts),
		.done  (done),
		.result(result)
	);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither in progress nor answered");

	a_zero_unless_removed: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != smpq_pkg::ST_REMOVED |-> result.removed_value == '0)
		else $error("removed_value nonzero without a remove");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == smpq_pkg::ST_EMPTY |-> result.count == '0)
		else $error("empty status with nonzero count");

endmodule

`default_nettype wire
